// ===== rtl/core/bks_pkg.sv =====
// Shared types and constants for the bounded unique key set.
package bks_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_DUP    = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  localparam int CAP_BITS   = 7;
  localparam int COUNT_BITS = 7;
  localparam int KEY_PORT_BITS = 32;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic                  done;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] count;
  } seq_res_t;

endpackage

// ===== rtl/core/bks_mem.sv =====
// Key storage: one write port and one registered read port.
module bks_mem #(
  parameter int DEPTH = 64,
  parameter int W     = 32,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/bks_seq.sv =====
// Sequencer that walks the key list for search, append and shift-down compaction.
module bks_seq
  import bks_pkg::*;
#(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          command,
  input  logic [KEY_BITS-1:0] key_m,
  input  logic [CAP_BITS-1:0] capacity,
  input  logic                res_ok,
  output logic                idle,
  output seq_res_t            res,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [KEY_BITS-1:0] rd_data,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [KEY_BITS-1:0] wr_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0]          state, state_next;
  logic [1:0]          cmd_r, cmd_r_next;
  logic [KEY_BITS-1:0] key_r, key_r_next;
  logic [CW-1:0]       ra, ra_next;
  logic [CW-1:0]       ca, ca_next;
  logic                rv, rv_next;
  logic [CW-1:0]       held, held_next;
  logic [1:0]          status_r, status_r_next;

  logic                hit;
  logic                more;
  logic                full;
  logic [CW-1:0]       ca_dec;
  logic [CW+6:0]       held_wide;

  assign hit    = rv && (rd_data == key_r);
  assign more   = ra < held;
  assign ca_dec = ca - CW'(1);
  // The capacity limit saturates at DEPTH; held never exceeds DEPTH.
  assign full   = ({7'd0, held} >= {{CW{1'b0}}, capacity}) || (held == CW'(DEPTH));
  assign held_wide = {7'd0, held};

  assign idle       = (state == S_IDLE);
  assign rd_addr    = ra[AW-1:0];

  always_comb begin
    state_next    = state;
    cmd_r_next    = cmd_r;
    key_r_next    = key_r;
    ra_next       = ra;
    ca_next       = ca;
    rv_next       = rv;
    held_next     = held;
    status_r_next = status_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = held[AW-1:0];
    wr_data       = key_r;
    res.done      = 1'b0;
    res.status    = status_r;
    res.count     = held_wide[COUNT_BITS-1:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_r_next = command;
          key_r_next = key_m;
          ra_next    = '0;
          rv_next    = 1'b0;
          if (command == CMD_INSERT && full) begin
            status_r_next = ST_FULL;
            state_next    = S_RESP;
          end else begin
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          rv_next = 1'b0;
          if (cmd_r == CMD_INSERT) begin
            status_r_next = ST_DUP;
            state_next    = S_RESP;
          end else if (cmd_r == CMD_REMOVE) begin
            ra_next    = ca + CW'(1);
            state_next = S_SHIFT;
          end else begin
            status_r_next = ST_OK;
            state_next    = S_RESP;
          end
        end else if (more) begin
          rd_en   = 1'b1;
          ca_next = ra;
          ra_next = ra + CW'(1);
          rv_next = 1'b1;
        end else begin
          rv_next    = 1'b0;
          state_next = S_RESP;
          if (cmd_r == CMD_INSERT) begin
            wr_en         = 1'b1;
            held_next     = held + CW'(1);
            status_r_next = ST_OK;
          end else begin
            status_r_next = ST_ABSENT;
          end
        end
      end
      S_SHIFT: begin
        // Each entry read is written one place lower in the next cycle.
        if (rv) begin
          wr_en   = 1'b1;
          wr_addr = ca_dec[AW-1:0];
          wr_data = rd_data;
        end
        if (more) begin
          rd_en   = 1'b1;
          ca_next = ra;
          ra_next = ra + CW'(1);
          rv_next = 1'b1;
        end else begin
          rv_next = 1'b0;
          if (!rv) begin
            held_next     = held - CW'(1);
            status_r_next = ST_OK;
            state_next    = S_RESP;
          end
        end
      end
      S_RESP: begin
        res.done = res_ok;
        if (res_ok) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held  <= '0;
      rv    <= 1'b0;
    end else begin
      state <= state_next;
      held  <= held_next;
      rv    <= rv_next;
    end
    cmd_r    <= cmd_r_next;
    key_r    <= key_r_next;
    ra       <= ra_next;
    ca       <= ca_next;
    status_r <= status_r_next;
  end

endmodule

// ===== rtl/core/bounded_unique_key_set_top.sv =====
// Top level of the bounded unique key set: ports, capacity register and result register.
//
//   channel  direction  signals                          beat
//   cfg      in         cfg_we, cfg_data                 capacity write, no wait
//   in       in         in_valid, in_ready, command, key one command and key
//   out      out        out_valid, out_ready, status, count  one result
//
// An insert on a full set gets its result without a search. A search that misses (an append
// included) reads every held entry, and a query or duplicate insert that hits stops at that
// entry. A remove that hits goes on to shift the later entries down one place; the search
// and the shift-down both go through the single read port of the key memory.
// One item is in work at a time; in_ready is high only while the sequencer is idle and
// rises with the result, so the next beat can be accepted as soon as the result shows.
// A result waits in the output register, and a stalled result holds the sequencer.
// Reset clears the count and sets the capacity to 64; no clearing pass is needed.
module bounded_unique_key_set_top
  import bks_pkg::*;
#(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CAP_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic [KEY_PORT_BITS-1:0] key,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [COUNT_BITS-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CAP_BITS-1:0]               capacity;
  logic [KEY_BITS+KEY_PORT_BITS-1:0] key_wide;
  logic [KEY_BITS-1:0]               key_m;
  logic                              seq_idle;
  logic                              res_ok;
  seq_res_t                          res;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic [KEY_BITS-1:0]               rd_data;
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic [KEY_BITS-1:0]               wr_data;

  // Only the low KEY_BITS bits of the key take part; a key port narrower than KEY_BITS is zero extended.
  assign key_wide = {{KEY_BITS{1'b0}}, key};
  assign key_m    = key_wide[KEY_BITS-1:0];

  assign in_ready = seq_idle;
  assign res_ok   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res.done) begin
      status <= res.status;
      count  <= res.count;
    end
  end

  bks_seq #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid && in_ready),
    .command  (command),
    .key_m    (key_m),
    .capacity (capacity),
    .res_ok   (res_ok),
    .idle     (seq_idle),
    .res      (res),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  bks_mem #(
    .DEPTH (DEPTH),
    .W     (KEY_BITS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

// ===== rtl/core/bks_chk.sv =====
// Port-level checks for the bounded unique key set, bound to the top level.
module bks_chk
  import bks_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     cfg_we,
  input logic [CAP_BITS-1:0]      cfg_data,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [1:0]               command,
  input logic [KEY_PORT_BITS-1:0] key,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               status,
  input logic [COUNT_BITS-1:0]    count
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count))
    else $error("result changed while stalled");

  // Accepting a command starts work, so the input side closes at once.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // A new result appears only as the sequencer finishes an item.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work in progress");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind bounded_unique_key_set_top bks_chk u_bks_chk (.*);

// ===== dv/key_set_checker.sv =====
// Result checker for the bounded unique key set: predicts each result and compares it.
`timescale 1ns / 1ps
module key_set_checker
  import bks_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CAP_BITS-1:0]      cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               command,
  input  logic [KEY_PORT_BITS-1:0] key,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [1:0]               status,
  input  logic [COUNT_BITS-1:0]    count,
  output int                       mismatches,
  output int                       outstanding
);

  typedef struct packed {
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] count;
  } set_result_t;

  logic [KEY_PORT_BITS-1:0] held_keys [DEPTH];
  int unsigned              held_total;
  logic [CAP_BITS-1:0]      capacity;
  set_result_t              pending_results [$];

  // Position of k among the held keys, or held_total when it is not held.
  function automatic int unsigned find_slot(input logic [KEY_PORT_BITS-1:0] k);
    for (int unsigned i = 0; i < held_total; i++) begin
      if (held_keys[i] == k) return i;
    end
    return held_total;
  endfunction

  function automatic set_result_t apply_key_op(input logic [1:0] op,
                                               input logic [KEY_PORT_BITS-1:0] k);
    int unsigned limit;
    int unsigned slot;
    set_result_t r;
    limit = (capacity > DEPTH) ? DEPTH : capacity;
    slot  = find_slot(k);
    case (op)
      CMD_INSERT: begin
        // The full check comes before the duplicate search.
        if (held_total >= limit) begin
          r.status = ST_FULL;
        end else if (slot < held_total) begin
          r.status = ST_DUP;
        end else begin
          held_keys[held_total] = k;
          held_total++;
          r.status = ST_OK;
        end
      end
      CMD_REMOVE: begin
        if (slot < held_total) begin
          for (int unsigned j = slot; j + 1 < held_total; j++) begin
            held_keys[j] = held_keys[j + 1];
          end
          held_total--;
          r.status = ST_OK;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      // The unused command value behaves as a query.
      default: begin
        r.status = (slot < held_total) ? ST_OK : ST_ABSENT;
      end
    endcase
    r.count = COUNT_BITS'(held_total);
    return r;
  endfunction

  always @(posedge clk) begin
    set_result_t want;
    if (rst) begin
      held_total = 0;
      capacity   = CAP_RESET;
      mismatches = 0;
      pending_results.delete();
    end else begin
      if (cfg_we) capacity = cfg_data;
      // Retire the result beat before predicting a new command in the same cycle.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result beat, got status %0d count %0d",
                   $time, status, count);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, status);
          end
          if (count !== want.count) begin
            mismatches++;
            $display("%0t: count expected %0d, got %0d", $time, want.count, count);
          end
        end
      end
      if (in_valid && in_ready) pending_results.push_back(apply_key_op(command, key));
    end
    outstanding <= pending_results.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the bounded unique key set: stimulus, handshakes, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top
  import bks_pkg::*;
();

  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         POOL_SIZE      = 80;
  localparam int         WATCHDOG_LIMIT = 4000;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CAP_BITS-1:0]      cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               command;
  logic [KEY_PORT_BITS-1:0] key;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic [COUNT_BITS-1:0]    count;

  int mismatches;
  int outstanding;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  logic [KEY_PORT_BITS-1:0] key_pool [POOL_SIZE];

  bounded_unique_key_set_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .count     (count)
  );

  key_set_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .key         (key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .count       (count),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bounded_unique_key_set_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Valid stays high across back-to-back beats; it drops only during an idle gap or a drain.
  task automatic send_beat(input logic [1:0] op, input logic [KEY_PORT_BITS-1:0] k);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= op;
    key      <= k;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [1:0] pick_command(input int insert_share);
    int unsigned r;
    if ($urandom_range(99) < insert_share) return CMD_INSERT;
    r = $urandom_range(9);
    if (r < 5) return CMD_REMOVE;
    if (r < 9) return CMD_QUERY;
    return CMD_UNUSED;
  endfunction

  // Most keys come from a shared pool so that hits and duplicates are common.
  function automatic logic [KEY_PORT_BITS-1:0] pick_key(input int span);
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(span - 1)];
    return $urandom;
  endfunction

  task automatic run_phase(input logic [CAP_BITS-1:0] cap, input int idle, input int stall,
                           input int beats, input int span, input int insert_share);
    write_capacity(cap);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < beats; i++) begin
      if (i == beats / 2) drain();
      send_beat(pick_command(insert_share), pick_key(span));
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    command   = CMD_INSERT;
    key       = '0;
    idle_pct  = 0;
    stall_pct = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset capacity.
    send_beat(CMD_QUERY,  32'h0000_0000);
    send_beat(CMD_REMOVE, 32'h0000_0000);
    send_beat(CMD_INSERT, 32'h0000_0000);
    send_beat(CMD_INSERT, 32'hFFFF_FFFF);
    send_beat(CMD_INSERT, 32'h0000_0000);
    send_beat(CMD_UNUSED, 32'h0000_0000);
    send_beat(CMD_UNUSED, 32'h0000_0005);
    send_beat(CMD_INSERT, 32'h1234_5678);
    send_beat(CMD_REMOVE, 32'h0000_0000);
    send_beat(CMD_QUERY,  32'h0000_0000);
    send_beat(CMD_QUERY,  32'h1234_5678);
    send_beat(CMD_INSERT, 32'hA5A5_A5A5);
    send_beat(CMD_INSERT, 32'h5A5A_5A5A);
    send_beat(CMD_REMOVE, 32'hFFFF_FFFF);
    send_beat(CMD_QUERY,  32'h5A5A_5A5A);

    // Capacity below the count: inserts are full even for a held key.
    write_capacity(7'd2);
    send_beat(CMD_INSERT, 32'h0000_0001);
    send_beat(CMD_INSERT, 32'h1234_5678);
    send_beat(CMD_QUERY,  32'hA5A5_A5A5);
    send_beat(CMD_REMOVE, 32'hA5A5_A5A5);
    send_beat(CMD_INSERT, 32'h0000_0001);
    send_beat(CMD_REMOVE, 32'h5A5A_5A5A);
    send_beat(CMD_INSERT, 32'h1234_5678);
    send_beat(CMD_INSERT, 32'h0000_0001);

    write_capacity(7'd0);
    send_beat(CMD_INSERT, 32'h0000_0002);
    send_beat(CMD_REMOVE, 32'h0000_0001);

    // Random part: capacity, idle, stall, beats, key span, insert share.
    run_phase(7'd64,  0,  0,  200, 80, 70);
    run_phase(7'd127, 77, 0,  200, 80, 50);
    run_phase(7'd10,  0,  77, 200, 80, 30);
    run_phase(7'd0,   37, 37, 100, 20, 40);
    run_phase(7'd1,   0,  0,  150, 4,  50);
    run_phase(7'd100, 37, 37, 200, 80, 65);
    run_phase(7'd64,  77, 0,  200, 40, 50);
    run_phase(7'd33,  0,  77, 200, 80, 55);
    run_phase(7'd5,   37, 37, 120, 8,  50);

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("bounded_unique_key_set_top: match");
    end else begin
      $display("bounded_unique_key_set_top: mismatch");
    end
    $finish;
  end

endmodule
